>>> src/qpi_pkg.sv
// qpi_pkg: shared types, sizes and codes for the positional-insert queue
// no dependencies; imported by queue_with_positional_insert_core
`timescale 1ns / 1ps
`default_nettype none

package qpi_pkg;

  // queue geometry
  localparam int DEPTH = 16;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // fixed field widths of the request and result
  localparam int CMD_W  = 2;
  localparam int DATA_W = 32;
  localparam int POS_W  = 5;
  localparam int STAT_W = 2;
  localparam int OCC_W  = 5;

  // width that holds both a position and a count without loss
  localparam int AT_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [CNT_W-1:0]         cnt_t;
  typedef logic [IDX_W-1:0]         idx_t;
  typedef logic [AT_W-1:0]          at_t;
  typedef logic [POS_W-1:0]         pos_t;
  typedef logic [OCC_W-1:0]         occ_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH   = 2'd0,
    CMD_POP    = 2'd1,
    CMD_INSERT = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_POS   = 2'd3
  } status_t;

endpackage

`default_nettype wire

>>> src/queue_with_positional_insert_core.sv
// queue_with_positional_insert_core: bounded ordered queue with push, pop and
// insert at a position; one result per request. depends on qpi_pkg
`timescale 1ns / 1ps
`default_nettype none

//  channel | signals                                    | direction
//  --------+--------------------------------------------+-----------
//  in      | in_valid, in_ready, cmd, value, position   | request in
//  out     | out_valid, out_ready, status, front_value, | result out
//          | rear_value, occupancy                      |
//
//  one request per cycle while results are drained: a request is decoded, the
//  queue entries updated and the result registered in the cycle it is
//  accepted; the result shows in the cycle after. the depth of the path is set
//  by the per-entry hold/shift/load select followed by the rear-entry read mux.
//  rst clears the fill count and the result valid; entries need no reset.
//  a stalled result holds in the result register; a new request is taken as
//  soon as that register is empty or being drained in the same cycle.

module queue_with_positional_insert_core (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire  [qpi_pkg::CMD_W-1:0]    cmd,
  input  wire  signed [qpi_pkg::DATA_W-1:0] value,
  input  wire  [qpi_pkg::POS_W-1:0]    position,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic [qpi_pkg::STAT_W-1:0]   status,
  output logic signed [qpi_pkg::DATA_W-1:0] front_value,
  output logic signed [qpi_pkg::DATA_W-1:0] rear_value,
  output logic [qpi_pkg::OCC_W-1:0]    occupancy
);

  import qpi_pkg::*;

  // queue storage: entry 0 is the front, fill_count-1 the rear
  data_t   entries      [DEPTH];
  data_t   entries_next [DEPTH];
  cnt_t    fill_count;
  cnt_t    fill_count_next;

  logic    accept;
  cmd_t    cmd_in;
  at_t     at;
  at_t     cnt_ext;
  logic    is_full;
  logic    is_empty;
  logic    do_put;
  logic    do_pop;
  status_t status_next;
  data_t   front_next;
  data_t   rear_next;
  idx_t    rear_idx;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  assign cmd_in   = cmd_t'(cmd);
  assign cnt_ext  = AT_W'(fill_count);
  assign is_full  = (fill_count == CNT_W'(DEPTH));
  assign is_empty = (fill_count == '0);

  // decode: push appends at the count, insert uses the given position
  always_comb begin
    at          = cnt_ext;
    do_put      = 1'b0;
    do_pop      = 1'b0;
    status_next = ST_OK;
    unique case (cmd_in) inside
      CMD_PUSH, CMD_INSERT: begin
        if (cmd_in == CMD_INSERT) begin
          at = AT_W'(position);
        end
        if (is_full) begin
          status_next = ST_FULL;           // full check wins over position
        end else if (at > cnt_ext) begin
          status_next = ST_POS;            // would leave a hole
        end else begin
          do_put = 1'b1;
        end
      end
      CMD_POP: begin
        if (is_empty) begin
          status_next = ST_EMPTY;
        end else begin
          do_pop = 1'b1;
        end
      end
      default: begin
        // unused code: report the current state
      end
    endcase
  end

  // every entry picks hold, shift back, shift forward or load in parallel
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      entries_next[i] = entries[i];
      if (do_put) begin
        if (AT_W'(i) == at) begin
          entries_next[i] = value;
        end else if (i > 0 && AT_W'(i) > at && AT_W'(i) <= cnt_ext) begin
          entries_next[i] = entries[(i > 0) ? i - 1 : 0];
        end
      end else if (do_pop && i < DEPTH - 1) begin
        entries_next[i] = entries[(i < DEPTH - 1) ? i + 1 : i];
      end
    end
  end

  always_comb begin
    fill_count_next = fill_count;
    if (do_put) begin
      fill_count_next = fill_count + CNT_W'(1);
    end else if (do_pop) begin
      fill_count_next = fill_count - CNT_W'(1);
    end
  end

  // result taken from the updated queue; zeros when it ends up empty
  assign rear_idx = IDX_W'(fill_count_next - CNT_W'(1));

  always_comb begin
    if (fill_count_next == '0) begin
      front_next = '0;
      rear_next  = '0;
    end else begin
      front_next = entries_next[0];
      rear_next  = entries_next[rear_idx];
    end
  end

  // storage update
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < DEPTH; i++) begin
        entries[i] <= entries_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
    end else if (accept) begin
      fill_count <= fill_count_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status      <= status_next;
      front_value <= front_next;
      rear_value  <= rear_next;
      occupancy   <= OCC_W'(fill_count_next);
    end
  end

  // checks

  // the count never passes the depth
  assert property (@(posedge clk) disable iff (rst)
    fill_count <= CNT_W'(DEPTH))
    else $error("fill count beyond depth");

  // an accepted request moves the count by at most one
  assert property (@(posedge clk) disable iff (rst)
    accept |=> (fill_count == $past(fill_count) ||
                fill_count == $past(fill_count) + CNT_W'(1) ||
                fill_count == $past(fill_count) - CNT_W'(1)))
    else $error("fill count jumped");

  // a full status is only reported with the queue at its depth
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_FULL) |-> occupancy == OCC_W'(DEPTH))
    else $error("full status with room left");

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && occupancy == '0) |-> (front_value == '0 && rear_value == '0))
    else $error("empty queue reports nonzero values");

endmodule

`default_nettype wire
